### rtl/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define CHK_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on the rising clock edge, off during reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/bvfr_pkg.sv
// shared constants, types and codes of the vector field resampler
package bvfr_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int FRAC_BITS  = 8;

   localparam int IDX_W     = 8;
   localparam int VEC_W     = 16;
   localparam int SZ_W      = 9;
   localparam int CSR_IDX_W = 2;

   localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int COORD_W   = $clog2(MAX_DIM);
   localparam int ADDR_W    = $clog2(MAX_WIDTH * MAX_HEIGHT);

   // divider: numerator (2i+1)*src*2^F, denominator 2*dst, two quotient bits a step
   localparam int PROD_W    = IDX_W + 1 + SZ_W;
   localparam int NUM_W     = PROD_W + FRAC_BITS;
   localparam int DIV_STEPS = (NUM_W + 1) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;
   localparam int DEN_W     = SZ_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int IP_W      = DIV_W + 1 - FRAC_BITS;

   // blend datapath
   localparam int W_W       = 2 * FRAC_BITS + 1;
   localparam int MUL_A_W   = (VEC_W > FRAC_BITS + 1) ? VEC_W : FRAC_BITS + 1;
   localparam int ACC_W     = VEC_W + 2 * FRAC_BITS;

   localparam logic [VEC_W-1:0]     SIGN_FLIP = {1'b1, {(VEC_W-1){1'b0}}};
   localparam logic [FRAC_BITS:0]   SCALE     = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [ACC_W-1:0]     ROUND     = ACC_W'(1) << (2 * FRAC_BITS - 1);
   localparam logic [DIV_W:0]       HALF_POS  = (DIV_W+1)'(1) << (FRAC_BITS - 1);

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_SAMPLE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 2'd0,
      CSR_SRC_HEIGHT = 2'd1,
      CSR_DST_WIDTH  = 2'd2,
      CSR_DST_HEIGHT = 2'd3
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_XGO,
      ST_XWAIT,
      ST_YGO,
      ST_YWAIT,
      ST_WGT,
      ST_ACCX,
      ST_ACCY,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      MAC_NOP,
      MAC_CLEAR,
      MAC_WEIGHT,
      MAC_ACC_X,
      MAC_ACC_Y
   } mac_cmd_type;

   typedef struct packed {
      mac_cmd_type          cmd;
      logic [FRAC_BITS:0]   wu;
      logic [FRAC_BITS:0]   wv;
   } mac_ctl_type;

   typedef struct packed {
      logic [COORD_W-1:0]   lo;
      logic [COORD_W-1:0]   hi;
      logic [FRAC_BITS-1:0] frac;
   } axis_type;

endpackage

### rtl/bvfr_ram.sv
// generic single-write, single-read ram with registered read data
module bvfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/bvfr_div.sv
// iterative unsigned divider, restoring, two quotient bits per cycle
module bvfr_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bvfr_pkg::DIV_W-1:0] num,
   input  logic [bvfr_pkg::DEN_W-1:0] den,
   output logic                       done,
   output logic [bvfr_pkg::DIV_W-1:0] quo
);
   import bvfr_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]     rem_ff, den_ff;
   logic [DIV_W-1:0]     wrk_ff;

   logic [DEN_W:0]       r1, r2, r1_sub, r2_sub;
   logic                 ge1, ge2;
   logic [DEN_W-1:0]     r1_keep, rem_in;
   logic [DIV_W-1:0]     wrk_in;

   // wrk holds the numerator bits still to come at the top, quotient bits at the bottom
   always_comb begin
      r1      = {rem_ff, wrk_ff[DIV_W-1]};
      ge1     = (r1 >= {1'b0, den_ff});
      r1_sub  = r1 - {1'b0, den_ff};
      r1_keep = ge1 ? r1_sub[DEN_W-1:0] : r1[DEN_W-1:0];
      r2      = {r1_keep, wrk_ff[DIV_W-2]};
      ge2     = (r2 >= {1'b0, den_ff});
      r2_sub  = r2 - {1'b0, den_ff};
      rem_in  = ge2 ? r2_sub[DEN_W-1:0] : r2[DEN_W-1:0];
      wrk_in  = {wrk_ff[DIV_W-3:0], ge1, ge2};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         wrk_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         wrk_ff <= wrk_in;
         rem_ff <= rem_in;
      end
   end

   assign done = done_ff;
   assign quo  = wrk_ff;

endmodule

### rtl/bvfr_mac.sv
// shared multiplier with weight register and two rounding accumulators
module bvfr_mac (
   input  logic                       clock,
   input  bvfr_pkg::mac_ctl_type      ctl,
   input  logic [bvfr_pkg::VEC_W-1:0] rd_x,
   input  logic [bvfr_pkg::VEC_W-1:0] rd_y,
   output logic [bvfr_pkg::VEC_W-1:0] vec_x,
   output logic [bvfr_pkg::VEC_W-1:0] vec_y
);
   import bvfr_pkg::*;

   logic [W_W-1:0]         w_ff;
   logic [ACC_W-1:0]       accx_ff, accy_ff;
   logic [MUL_A_W-1:0]     mul_a;
   logic [W_W-1:0]         mul_b;
   logic [MUL_A_W+W_W-1:0] prod;

   // vector values are offset to unsigned; the weights sum to 2^2F so the offset survives
   always_comb begin
      unique case (ctl.cmd)
         MAC_WEIGHT: begin
            mul_a = MUL_A_W'(ctl.wu);
            mul_b = W_W'(ctl.wv);
         end
         MAC_ACC_X: begin
            mul_a = MUL_A_W'(rd_x ^ SIGN_FLIP);
            mul_b = w_ff;
         end
         MAC_ACC_Y: begin
            mul_a = MUL_A_W'(rd_y ^ SIGN_FLIP);
            mul_b = w_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = {{W_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

   always_ff @(posedge clock) begin
      unique case (ctl.cmd)
         MAC_CLEAR: begin
            accx_ff <= ROUND;
            accy_ff <= ROUND;
         end
         MAC_WEIGHT: w_ff    <= prod[W_W-1:0];
         MAC_ACC_X:  accx_ff <= accx_ff + prod[ACC_W-1:0];
         MAC_ACC_Y:  accy_ff <= accy_ff + prod[ACC_W-1:0];
         default: begin
         end
      endcase
   end

   assign vec_x = accx_ff[ACC_W-1 -: VEC_W] ^ SIGN_FLIP;
   assign vec_y = accy_ff[ACC_W-1 -: VEC_W] ^ SIGN_FLIP;

endmodule

### rtl/bilinear_vector_field_resize_top.sv
// Bilinear resampler of a two-component Q8.8 vector field with half-pixel centres.
// A load item (req_op = 0) writes one source vector into the 256x256 field store and
// busy stays low. A sample item (req_op = 1) holds busy high through its result
// strobe; the next item is taken after it. It runs two 13-step radix-4 divisions
// for the column and row positions, run one after the other through the single
// divider, then three passes of the single multiplier per neighbor (weight, x, y)
// over four field reads. rsp_valid is high for exactly one cycle per sample and the
// result must be taken then. Configuration writes are taken in any cycle and belong
// to idle periods; a field entry must be loaded before a sample reads it.
module bilinear_vector_field_resize_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [bvfr_pkg::IDX_W-1:0]         req_row_index,
   input  logic [bvfr_pkg::IDX_W-1:0]         req_col_index,
   input  logic signed [bvfr_pkg::VEC_W-1:0]  req_vec_x_in,
   input  logic signed [bvfr_pkg::VEC_W-1:0]  req_vec_y_in,
   output logic                               rsp_valid,
   output logic [bvfr_pkg::IDX_W-1:0]         rsp_out_row,
   output logic [bvfr_pkg::IDX_W-1:0]         rsp_out_col,
   output logic signed [bvfr_pkg::VEC_W-1:0]  rsp_vec_x_out,
   output logic signed [bvfr_pkg::VEC_W-1:0]  rsp_vec_y_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bvfr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bvfr_pkg::SZ_W-1:0]          csr_wdata
);
   import bvfr_pkg::*;

   state_type            state_ff, state_in;
   logic [1:0]           nbr_ff, nbr_in;
   logic [SZ_W-1:0]      src_width_ff, src_height_ff, dst_width_ff, dst_height_ff;

   logic [IDX_W-1:0]     row_ff, col_ff;
   logic [SZ_W-1:0]      sw_ff, sh_ff, dw_ff, dh_ff;
   logic [COORD_W-1:0]   x0_ff, x1_ff, y0_ff, y1_ff;
   logic [FRAC_BITS-1:0] u_ff, v_ff;

   logic                 accept, sample_go, load_go, load_in_range;
   logic                 div_start, div_done, use_y;
   logic [DIV_W-1:0]     div_num, div_quo;
   logic [DEN_W-1:0]     div_den;
   logic [IDX_W:0]       odd_idx;
   logic [SZ_W-1:0]      src_sel, dst_sel, sw_clamp, sh_clamp, dw_clamp, dh_clamp;
   logic [PROD_W-1:0]    num_prod;
   axis_type             axis;
   mac_ctl_type          mac_ctl;
   logic [COORD_W-1:0]   x_sel, y_sel;
   logic [ADDR_W-1:0]    wr_addr, rd_addr;
   logic [2*VEC_W-1:0]   rd_data;
   logic [VEC_W-1:0]     mac_vx, mac_vy;

   // floor and ceil of the mapped position, clamped to the source frame
   function automatic axis_type map_axis(input logic [DIV_W-1:0] q,
                                         input logic [SZ_W-1:0]  src);
      logic [DIV_W:0]       pp;
      logic [IP_W-1:0]      ip, a, b, lim;
      logic [FRAC_BITS-1:0] f;
      axis_type             r;
      pp  = {1'b0, q} + HALF_POS;
      ip  = pp[DIV_W:FRAC_BITS];
      f   = pp[FRAC_BITS-1:0];
      lim = IP_W'(src) - IP_W'(1);
      a   = (ip == '0) ? '0 : ip - IP_W'(1);
      b   = (ip == '0) ? '0 : ((f != '0) ? ip : a);
      if (a > lim) a = lim;
      if (b > lim) b = lim;
      r.lo   = a[COORD_W-1:0];
      r.hi   = b[COORD_W-1:0];
      r.frac = f;
      return r;
   endfunction

   function automatic logic [SZ_W-1:0] clamp_src(input logic [SZ_W-1:0] v, input int hi);
      logic [SZ_W-1:0] r;
      r = v;
      if (v == '0) r = SZ_W'(1);
      else if (int'(v) > hi) r = SZ_W'(hi);
      return r;
   endfunction

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign sample_go = accept && (req_op == OP_SAMPLE);
   assign load_go   = accept && (req_op == OP_LOAD);
   assign csr_ready = 1'b1;

   assign sw_clamp = clamp_src(src_width_ff, MAX_WIDTH);
   assign sh_clamp = clamp_src(src_height_ff, MAX_HEIGHT);
   assign dw_clamp = (dst_width_ff == '0) ? SZ_W'(1) : dst_width_ff;
   assign dh_clamp = (dst_height_ff == '0) ? SZ_W'(1) : dst_height_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff  <= SZ_W'(256);
         src_height_ff <= SZ_W'(256);
         dst_width_ff  <= SZ_W'(256);
         dst_height_ff <= SZ_W'(256);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_idx_type'(csr_index))
            CSR_SRC_WIDTH:  src_width_ff  <= csr_wdata;
            CSR_SRC_HEIGHT: src_height_ff <= csr_wdata;
            CSR_DST_WIDTH:  dst_width_ff  <= csr_wdata;
            CSR_DST_HEIGHT: dst_height_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      nbr_in   = nbr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            nbr_in = '0;
            if (sample_go) state_in = ST_XGO;
         end
         ST_XGO:   state_in = ST_XWAIT;
         ST_XWAIT: if (div_done) state_in = ST_YGO;
         ST_YGO:   state_in = ST_YWAIT;
         ST_YWAIT: if (div_done) state_in = ST_WGT;
         ST_WGT:   state_in = ST_ACCX;
         ST_ACCX:  state_in = ST_ACCY;
         ST_ACCY: begin
            nbr_in = nbr_ff + 2'd1;
            state_in = (nbr_ff == 2'd3) ? ST_DONE : ST_WGT;
         end
         ST_DONE:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      div_start   = 1'b0;
      use_y       = 1'b0;
      rsp_valid   = 1'b0;
      mac_ctl.cmd = MAC_NOP;
      // neighbor order: (x0,y0) (x0,y1) (x1,y0) (x1,y1)
      mac_ctl.wu  = nbr_ff[1] ? {1'b0, u_ff} : SCALE - {1'b0, u_ff};
      mac_ctl.wv  = nbr_ff[0] ? {1'b0, v_ff} : SCALE - {1'b0, v_ff};
      unique case (state_ff)
         ST_IDLE: if (sample_go) mac_ctl.cmd = MAC_CLEAR;
         ST_XGO:  div_start = 1'b1;
         ST_YGO: begin
            div_start = 1'b1;
            use_y     = 1'b1;
         end
         ST_WGT:  mac_ctl.cmd = MAC_WEIGHT;
         ST_ACCX: mac_ctl.cmd = MAC_ACC_X;
         ST_ACCY: mac_ctl.cmd = MAC_ACC_Y;
         ST_DONE: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nbr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         nbr_ff   <= nbr_in;
      end
   end

   // item and axis registers
   always_ff @(posedge clock) begin
      if (sample_go) begin
         row_ff <= req_row_index;
         col_ff <= req_col_index;
         sw_ff  <= sw_clamp;
         sh_ff  <= sh_clamp;
         dw_ff  <= dw_clamp;
         dh_ff  <= dh_clamp;
      end
      if (state_ff == ST_XWAIT && div_done) begin
         x0_ff <= axis.lo;
         x1_ff <= axis.hi;
         u_ff  <= axis.frac;
      end
      if (state_ff == ST_YWAIT && div_done) begin
         y0_ff <= axis.lo;
         y1_ff <= axis.hi;
         v_ff  <= axis.frac;
      end
   end

   // numerator (2i+1)*src*2^F and denominator 2*dst
   assign odd_idx  = use_y ? {row_ff, 1'b1} : {col_ff, 1'b1};
   assign src_sel  = use_y ? sh_ff : sw_ff;
   assign dst_sel  = use_y ? dh_ff : dw_ff;
   assign num_prod = {{SZ_W{1'b0}}, odd_idx} * {{(IDX_W+1){1'b0}}, src_sel};
   assign div_num  = DIV_W'({num_prod, {FRAC_BITS{1'b0}}});
   assign div_den  = {dst_sel, 1'b0};

   bvfr_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign axis = map_axis(div_quo, (state_ff == ST_YWAIT) ? sh_ff : sw_ff);

   assign x_sel      = nbr_ff[1] ? x1_ff : x0_ff;
   assign y_sel      = nbr_ff[0] ? y1_ff : y0_ff;
   assign rd_addr    = ADDR_W'(int'(y_sel) * MAX_WIDTH + int'(x_sel));

   assign load_in_range = (int'(req_row_index) < MAX_HEIGHT) &&
                          (int'(req_col_index) < MAX_WIDTH);
   assign wr_addr       = ADDR_W'(int'(req_row_index) * MAX_WIDTH + int'(req_col_index));

   bvfr_ram #(
      .WIDTH (2 * VEC_W),
      .DEPTH (MAX_WIDTH * MAX_HEIGHT)
   ) u_field (
      .clock   (clock),
      .wr_en   (load_go && load_in_range),
      .wr_addr (wr_addr),
      .wr_data ({req_vec_x_in, req_vec_y_in}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bvfr_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .rd_x  (rd_data[2*VEC_W-1:VEC_W]),
      .rd_y  (rd_data[VEC_W-1:0]),
      .vec_x (mac_vx),
      .vec_y (mac_vy)
   );

   assign rsp_out_row   = row_ff;
   assign rsp_out_col   = col_ff;
   assign rsp_vec_x_out = $signed(mac_vx);
   assign rsp_vec_y_out = $signed(mac_vy);

endmodule

### rtl/bvfr_checker.sv
// port-level checks of the resampler sequencing, bound to the top level
`include "assert_macros.svh"

module bvfr_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_op,
   input logic rsp_valid
);
   import bvfr_pkg::*;

   // a result only comes out of a sample in flight
   `CHK_IMPLIES(a_rsp_while_busy, clock, reset, rsp_valid, busy, "result strobe while idle")

   // the strobe lasts one cycle and ends the sample
   `CHK_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid && !busy, "result strobe not single")

   // a load item never occupies the block
   `CHK_NEXT(a_load_free, clock, reset, start && !busy && (req_op == OP_LOAD), !busy, "load held block")

   // an accepted sample starts work and cannot answer at once
   `CHK_NEXT(a_sample_taken, clock, reset, start && !busy && (req_op == OP_SAMPLE), busy && !rsp_valid, "sample not started")

endmodule

bind bilinear_vector_field_resize_top bvfr_checker u_bvfr_checker (.*);
